[rtl/core/b64sd_pkg.sv]
// Shared types, constants and character classification for the Base64 stream decoder.
package b64sd_pkg;

    localparam int CHAR_W     = 8;
    localparam int SEXTET_W   = 6;
    localparam int GROUP_W    = 3 * SEXTET_W;
    localparam int WORD_W     = 24;
    localparam int CODE_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_PAD    = 8'd61;
    localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'd90;
    localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'd122;
    localparam logic [CHAR_W-1:0] CHAR_DIG_0  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_DIG_9  = 8'd57;
    localparam logic [CHAR_W-1:0] RST_CHAR_62 = 8'd43;
    localparam logic [CHAR_W-1:0] RST_CHAR_63 = 8'd47;

    localparam logic [CODE_W-1:0] CODE_LO_BASE  = 7'd26;
    localparam logic [CODE_W-1:0] CODE_DIG_BASE = 7'd52;
    localparam logic [CODE_W-1:0] CODE_62       = 7'd62;
    localparam logic [CODE_W-1:0] CODE_63       = 7'd63;
    localparam logic [CODE_W-1:0] CODE_PAD      = 7'd64;
    localparam logic [CODE_W-1:0] CODE_BAD      = 7'd65;

    localparam logic [CFG_IDX_W-1:0] REG_CHAR_62 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_63 = 1'd1;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              run_last;
        logic              stream_end;
        logic              error_flag;
    } out_word_t;

    // One decoded group waiting for the back end.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              second_en;
        logic              third_en;
        logic              stream_end;
        logic              error;
    } group_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        SEL_B0,
        SEL_B1,
        SEL_B2
    } byte_sel_t;

    function automatic logic [CODE_W-1:0] classify(
        input logic [CHAR_W-1:0] c,
        input logic [CHAR_W-1:0] a62,
        input logic [CHAR_W-1:0] a63
    );
        logic [CHAR_W-1:0] t;
        t = '0;
        if (c == CHAR_PAD) begin
            return CODE_PAD;
        end
        else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            t = c - CHAR_UP_A;
            return {1'b0, t[SEXTET_W-1:0]};
        end
        else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            t = c - CHAR_LO_A;
            return {1'b0, t[SEXTET_W-1:0]} + CODE_LO_BASE;
        end
        else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
            t = c - CHAR_DIG_0;
            return {1'b0, t[SEXTET_W-1:0]} + CODE_DIG_BASE;
        end
        else if (c == a62) begin
            return CODE_62;
        end
        else if (c == a63) begin
            return CODE_63;
        end
        return CODE_BAD;
    endfunction

endpackage

[rtl/core/base64_stream_decoder.sv]
// Top level of the Base64 stream decoder: front end, record queue, back end.
//
//  channel  | handshake          | word
//  ---------+--------------------+-------------------------------------------------
//  input    | push / full        | in_data: char_code, end_of_input
//  result   | empty / pop        | out_data: data_byte, run_last, stream_end, error_flag
//  config   | cfg_wr_en          | cfg_index (0: char 62, 1: char 63), cfg_wdata
//
//  One character is accepted per cycle while the queue is not full; a group's record enters the queue at that edge.
//  The back end sends one byte per cycle while pop is held, from the queue head via an output
//  register loaded after the record is written; throughput is set by the result port.
//  full rises only when the four-entry record queue is full.
//  Reset clears group state, queue pointers and output valid flag, and loads '+' and '/'.
module base64_stream_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  b64sd_pkg::in_word_t             in_data,
    output logic                            empty,
    input  logic                            pop,
    output b64sd_pkg::out_word_t            out_data,
    input  logic                            cfg_wr_en,
    input  logic [b64sd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [b64sd_pkg::CHAR_W-1:0]    cfg_wdata
);
    import b64sd_pkg::*;

    fifo_stat_t  fifo_stat;
    logic        rec_wr;
    logic        rec_rd;
    group_rec_t  rec_wr_data;
    group_rec_t  rec_rd_data;

    assign full = fifo_stat.full;

    b64sd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_data   (in_data),
        .fifo_stat (fifo_stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rec_wr    (rec_wr),
        .rec_data  (rec_wr_data)
    );

    b64sd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_wr),
        .wr_data (rec_wr_data),
        .rd_en   (rec_rd),
        .rd_data (rec_rd_data),
        .stat    (fifo_stat)
    );

    b64sd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_data  (rec_rd_data),
        .fifo_stat (fifo_stat),
        .rec_rd    (rec_rd),
        .pop       (pop),
        .empty     (empty),
        .out_data  (out_data)
    );

endmodule

[rtl/core/b64sd_front.sv]
// Front end: accepts characters, classifies them and assembles group records.
module b64sd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  b64sd_pkg::in_word_t           in_data,
    input  b64sd_pkg::fifo_stat_t         fifo_stat,
    input  logic                          cfg_wr_en,
    input  logic [b64sd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [b64sd_pkg::CHAR_W-1:0]  cfg_wdata,
    output logic                          rec_wr,
    output b64sd_pkg::group_rec_t         rec_data
);
    import b64sd_pkg::*;

    logic [CHAR_W-1:0]   char_62_reg;
    logic [CHAR_W-1:0]   char_63_reg;
    logic [GROUP_W-1:0]  group_sextets_reg, group_sextets_next;
    logic [1:0]          group_position_reg, group_position_next;
    logic                third_is_pad_reg, third_is_pad_next;
    logic                discard_mode_reg, discard_mode_next;

    logic                accept;
    logic [CODE_W-1:0]   code;
    logic                pad;
    logic [SEXTET_W-1:0] sextet;
    logic                third_pad;
    logic                fourth_pad;
    logic                emit;
    logic [WORD_W-1:0]   word;

    assign accept = push && !fifo_stat.full;
    assign code   = classify(in_data.char_code, char_62_reg, char_63_reg);
    assign pad    = (code == CODE_PAD);
    assign sextet = pad ? '0 : code[SEXTET_W-1:0];

    always_comb
    begin
        group_sextets_next  = group_sextets_reg;
        group_position_next = group_position_reg;
        third_is_pad_next   = third_is_pad_reg;
        discard_mode_next   = discard_mode_reg;
        emit                = 1'b0;
        word                = '0;
        third_pad           = 1'b1;
        fourth_pad          = 1'b1;
        rec_data            = '0;

        if (discard_mode_reg) begin
            if (in_data.end_of_input) begin
                group_sextets_next  = '0;
                group_position_next = POS_FIRST;
                third_is_pad_next   = 1'b0;
                discard_mode_next   = 1'b0;
            end
        end
        else if (code == CODE_BAD) begin
            emit                = 1'b1;
            rec_data.stream_end = 1'b1;
            rec_data.error      = 1'b1;
            group_sextets_next  = '0;
            group_position_next = POS_FIRST;
            third_is_pad_next   = 1'b0;
            discard_mode_next   = !in_data.end_of_input;
        end
        else begin
            unique case (group_position_reg)
                POS_FIRST:  word = {sextet, 18'd0};
                POS_SECOND: word = {group_sextets_reg[5:0], sextet, 12'd0};
                POS_THIRD:  word = {group_sextets_reg[11:0], sextet, 6'd0};
                default:    word = {group_sextets_reg, sextet};
            endcase

            if (group_position_reg == POS_FOURTH) begin
                third_pad  = third_is_pad_reg;
                fourth_pad = pad;
            end
            else if (group_position_reg == POS_THIRD) begin
                third_pad = pad;
            end

            if (group_position_reg == POS_FOURTH || in_data.end_of_input) begin
                emit                = 1'b1;
                rec_data.word       = word;
                rec_data.second_en  = !third_pad;
                rec_data.third_en   = !fourth_pad;
                rec_data.stream_end = in_data.end_of_input;
                group_sextets_next  = '0;
                group_position_next = POS_FIRST;
                third_is_pad_next   = 1'b0;
            end
            else begin
                group_sextets_next  = {group_sextets_reg[11:0], sextet};
                group_position_next = group_position_reg + 2'd1;
                if (group_position_reg == POS_THIRD) begin
                    third_is_pad_next = pad;
                end
            end
        end
    end

    assign rec_wr = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_62_reg        <= RST_CHAR_62;
            char_63_reg        <= RST_CHAR_63;
            group_sextets_reg  <= '0;
            group_position_reg <= POS_FIRST;
            third_is_pad_reg   <= 1'b0;
            discard_mode_reg   <= 1'b0;
        end
        else begin
            if (cfg_wr_en && cfg_index == REG_CHAR_62) begin
                char_62_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == REG_CHAR_63) begin
                char_63_reg <= cfg_wdata;
            end
            if (accept) begin
                group_sextets_reg  <= group_sextets_next;
                group_position_reg <= group_position_next;
                third_is_pad_reg   <= third_is_pad_next;
                discard_mode_reg   <= discard_mode_next;
            end
        end
    end

    a_discard_at_group_start: assert property (@(posedge clk) disable iff (!rst_n)
        discard_mode_reg |-> (group_position_reg == POS_FIRST && group_sextets_reg == '0))
        else $error("discard with partial group");

endmodule

[rtl/core/b64sd_fifo.sv]
// Short register queue of group records between front and back end.
module b64sd_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  b64sd_pkg::group_rec_t   wr_data,
    input  logic                    rd_en,
    output b64sd_pkg::group_rec_t   rd_data,
    output b64sd_pkg::fifo_stat_t   stat
);
    import b64sd_pkg::*;

    group_rec_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_AW:0]    count_reg, count_next;

    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !stat.full)
        else $error("record queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !stat.empty)
        else $error("record queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("record queue count out of range");

endmodule

[rtl/core/b64sd_back.sv]
// Back end: walks each group record and delivers its bytes through an output register.
module b64sd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  b64sd_pkg::group_rec_t   rec_data,
    input  b64sd_pkg::fifo_stat_t   fifo_stat,
    output logic                    rec_rd,
    input  logic                    pop,
    output logic                    empty,
    output b64sd_pkg::out_word_t    out_data
);
    import b64sd_pkg::*;

    byte_sel_t   sel_reg, sel_next;
    logic        out_valid_reg;
    out_word_t   out_reg;

    logic        load;
    logic        last;
    logic [CHAR_W-1:0] cur_byte;

    assign load = !fifo_stat.empty && (!out_valid_reg || pop);

    always_comb
    begin
        sel_next = SEL_B0;
        unique case (sel_reg)
            SEL_B0:
            begin
                if (rec_data.second_en) begin
                    sel_next = SEL_B1;
                end
                else if (rec_data.third_en) begin
                    sel_next = SEL_B2;
                end
            end
            SEL_B1:
            begin
                if (rec_data.third_en) begin
                    sel_next = SEL_B2;
                end
            end
            default:
            begin
                sel_next = SEL_B0;
            end
        endcase
    end

    always_comb
    begin
        cur_byte = rec_data.word[23:16];
        last     = 1'b1;
        unique case (sel_reg)
            SEL_B0:
            begin
                cur_byte = rec_data.word[23:16];
                last     = !rec_data.second_en && !rec_data.third_en;
            end
            SEL_B1:
            begin
                cur_byte = rec_data.word[15:8];
                last     = !rec_data.third_en;
            end
            SEL_B2:
            begin
                cur_byte = rec_data.word[7:0];
                last     = 1'b1;
            end
            default:
            begin
                cur_byte = rec_data.word[23:16];
                last     = 1'b1;
            end
        endcase
    end

    assign rec_rd   = load && last;
    assign empty    = !out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg.data_byte  <= cur_byte;
            out_reg.run_last   <= last;
            out_reg.stream_end <= last && rec_data.stream_end;
            out_reg.error_flag <= rec_data.error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sel_reg       <= SEL_B0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                sel_reg       <= sel_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_mid_record_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != SEL_B0) |-> !fifo_stat.empty)
        else $error("byte walk without a record");

endmodule

[dv/tb.sv]
// Self-checking testbench for base64_stream_decoder: scoreboard-based decode prediction.
module tb;
    import b64sd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    class decode_scoreboard;
        out_word_t          pending_bytes[$];
        logic [CHAR_W-1:0]  char62;
        logic [CHAR_W-1:0]  char63;
        logic [GROUP_W-1:0] sextets;
        logic [1:0]         gpos;
        bit                 third_pad;
        bit                 dropping;
        int                 errors;

        function new();
            char62   = RST_CHAR_62;
            char63   = RST_CHAR_63;
            dropping = 1'b0;
            errors   = 0;
            clear_group();
        endfunction

        function void clear_group();
            sextets   = '0;
            gpos      = POS_FIRST;
            third_pad = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAR_W-1:0] val);
            if (idx == REG_CHAR_62)
            begin
                char62 = val;
            end
            else
            begin
                char63 = val;
            end
        endfunction

        // '=' first, then letters and digits, then the two programmable codes
        function logic [CODE_W-1:0] char_value(logic [CHAR_W-1:0] c);
            if (c == CHAR_PAD)
                return CODE_PAD;
            if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
                return CODE_W'(c - CHAR_UP_A);
            if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
                return CODE_W'(c - CHAR_LO_A) + CODE_LO_BASE;
            if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9)
                return CODE_W'(c - CHAR_DIG_0) + CODE_DIG_BASE;
            if (c == char62)
                return CODE_62;
            if (c == char63)
                return CODE_63;
            return CODE_BAD;
        endfunction

        function void add_byte(logic [7:0] b, bit last, bit done, bit err);
            out_word_t w;
            w.data_byte  = b;
            w.run_last   = last;
            w.stream_end = done;
            w.error_flag = err;
            pending_bytes.push_back(w);
        endfunction

        // returns 0 when the word is dropped after an error
        function bit decode_char(in_word_t w);
            logic [CODE_W-1:0]   code;
            logic [SEXTET_W-1:0] s;
            logic [WORD_W-1:0]   word;
            logic [7:0]          bytes[3];
            bit                  pad;
            bit                  tp;
            bit                  fp;
            bit                  e;
            int                  n;
            e = w.end_of_input;
            if (dropping)
            begin
                if (e)
                begin
                    clear_group();
                    dropping = 1'b0;
                end
                return 1'b0;
            end
            code = char_value(w.char_code);
            if (code == CODE_BAD)
            begin
                add_byte(8'h00, 1'b1, 1'b1, 1'b1);
                clear_group();
                dropping = !e;
                return 1'b1;
            end
            pad = (code == CODE_PAD);
            s   = pad ? '0 : code[SEXTET_W-1:0];
            if (gpos != POS_FOURTH)
            begin
                sextets = {sextets[GROUP_W-SEXTET_W-1:0], s};
                if (gpos == POS_THIRD)
                    third_pad = pad;
                if (!e)
                begin
                    gpos = gpos + 2'd1;
                    return 1'b1;
                end
                word = WORD_W'(sextets) << (SEXTET_W * (3 - int'(gpos)));
                tp   = (gpos == POS_THIRD) ? third_pad : 1'b1;
                fp   = 1'b1;
            end
            else
            begin
                word = {sextets, s};
                tp   = third_pad;
                fp   = pad;
            end
            bytes[0] = word[23:16];
            n = 1;
            if (!tp)
            begin
                bytes[n] = word[15:8];
                n++;
            end
            if (!fp)
            begin
                bytes[n] = word[7:0];
                n++;
            end
            for (int k = 0; k < n; k++)
                add_byte(bytes[k], k == n - 1, (k == n - 1) && e, 1'b0);
            clear_group();
            return 1'b1;
        endfunction

        function void check_byte(out_word_t got);
            out_word_t want;
            if (pending_bytes.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("unexpected word: byte %h last %b end %b err %b",
                             got.data_byte, got.run_last, got.stream_end, got.error_flag);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.data_byte !== want.data_byte || got.run_last !== want.run_last ||
                got.stream_end !== want.stream_end || got.error_flag !== want.error_flag)
            begin
                if (errors < MAX_REPORTS)
                    $display("mismatch: exp byte %h last %b end %b err %b, got %h %b %b %b",
                             want.data_byte, want.run_last, want.stream_end, want.error_flag,
                             got.data_byte, got.run_last, got.stream_end, got.error_flag);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    in_word_t             in_data;
    logic                 empty;
    logic                 pop;
    out_word_t            out_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CHAR_W-1:0]    cfg_wdata;

    bit tx_idle;
    bit rx_idle;
    int quiet_cycles = 0;

    decode_scoreboard sb = new();

    base64_stream_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic send_char(logic [7:0] c, bit e, output bit used);
        in_word_t w;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        w.char_code    = c;
        w.end_of_input = e;
        push    <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (full);
        used = sb.decode_char(w);
    endtask

    task automatic send_text(string s);
        bit used;
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1, used);
    endtask

    task automatic drain(int cycles);
        push <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic set_alphabet(logic [7:0] c62, logic [7:0] c63);
        drain(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CHAR_62;
        cfg_wdata <= c62;
        @(posedge clk);
        sb.set_reg(REG_CHAR_62, c62);
        cfg_index <= REG_CHAR_63;
        cfg_wdata <= c63;
        @(posedge clk);
        sb.set_reg(REG_CHAR_63, c63);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] char_for(int v);
        if (v < 26)
            return CHAR_UP_A + 8'(v);
        if (v < 52)
            return CHAR_LO_A + 8'(v - 26);
        if (v < 62)
            return CHAR_DIG_0 + 8'(v - 52);
        return (v == 62) ? sb.char62 : sb.char63;
    endfunction

    // kind 0: noise, 1: one bad char, 2: full groups with up to two '=' at the tail, else free text
    task automatic random_streams(int count);
        int         sent;
        int         len;
        int         kind;
        int         bad_at;
        int         pad_tail;
        bit         used;
        bit         e;
        logic [7:0] c;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 2)
                len = 4 * $urandom_range(1, 3);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            bad_at   = (kind == 1) ? $urandom_range(0, len - 1) : -1;
            pad_tail = (kind == 2) ? $urandom_range(0, 2) : 0;
            for (int i = 0; i < len; i++)
            begin
                e = (i == len - 1);
                if (kind == 0)
                begin
                    c = 8'($urandom_range(0, 255));
                    e = e || ($urandom_range(0, 7) == 0);
                end
                else if (i == bad_at)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (sb.char_value(c) != CODE_BAD);
                end
                else if (i >= len - pad_tail || $urandom_range(0, 9) == 0)
                    c = CHAR_PAD;
                else
                    c = char_for($urandom_range(0, 63));
                send_char(c, e, used);
                if (used)
                    sent++;
            end
        end
    endtask

    initial
    begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_byte(out_data);
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 14);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        bit used;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        in_data   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_CHAR_62;
        cfg_wdata <= '0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full group, pad third only, early end with third pad
        send_text("+/azTQ=BZ9=");
        send_text("=");
        send_text("AB");
        // bad char, dropped words, end clears
        send_char(8'h00, 1'b0, used);
        send_char(8'hFF, 1'b0, used);
        send_char(8'h80, 1'b1, used);
        // bad char on the final word
        send_char(8'hFF, 1'b1, used);
        send_text("A9Z");

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_streams(20);
        set_alphabet(8'h00, 8'hFF);
        random_streams(22);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_alphabet(8'hFF, 8'h00);
        random_streams(22);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_alphabet(CHAR_UP_A, CHAR_PAD);
        random_streams(22);
        set_alphabet("-", "_");
        random_streams(22);
        set_alphabet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_streams(22);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_alphabet(RST_CHAR_62, RST_CHAR_63);
        random_streams(12);
        drain(DRAIN_CYCLES);

        if (sb.errors == 0 && sb.pending_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[sim.f]
rtl/core/b64sd_pkg.sv
rtl/core/b64sd_front.sv
rtl/core/b64sd_fifo.sv
rtl/core/b64sd_back.sv
rtl/core/base64_stream_decoder.sv
dv/tb.sv
